@@ rtl/core/bba_pkg.sv @@
// Package for the buddy block allocator: constants, payload structs,
// controller state enum, controller-datapath command enum and status struct.
// No dependencies.
package bba_pkg;

  localparam int OrderLimit = 10;
  localparam int UnitBytes = 64;
  localparam int TagBytes = 8;
  localparam int OrdW = 4;
  localparam int BlkW = OrderLimit;
  localparam int StoreDepth = 2 << OrderLimit;
  localparam int StoreAw = OrderLimit + 1;
  localparam int DepthW = OrderLimit + 1;
  localparam int BlockCount = 1 << OrderLimit;
  localparam logic [16:0] PoolReset = 17'd65536;

  typedef struct packed {
    logic        opcode;
    logic [31:0] request_bytes;
    logic [9:0]  free_block;
  } req_t;

  typedef struct packed {
    logic       granted;
    logic [9:0] block_start;
    logic [3:0] block_order;
  } rsp_t;

  typedef enum logic [3:0] {
    StIdle,
    StNeed,
    StFind,
    StPopRd,
    StPopWait,
    StSplit,
    StTagRd,
    StTagWait,
    StMrgChk,
    StScanRd,
    StScanWait,
    StScanCmp,
    StShiftRd,
    StShiftWait,
    StShiftWr,
    StPush
  } state_e;

  typedef enum logic [3:0] {
    CmdNone,
    CmdLoad,
    CmdNeedStep,
    CmdFindStep,
    CmdPopRead,
    CmdPopTake,
    CmdSplitStep,
    CmdTagRead,
    CmdTagTake,
    CmdScanStart,
    CmdScanRead,
    CmdScanNext,
    CmdShiftRead,
    CmdShiftWrite,
    CmdMerge,
    CmdPush
  } cmd_e;

  typedef struct packed {
    logic need_done;
    logic need_fail;
    logic find_done;
    logic find_fail;
    logic split_done;
    logic merge_end;
    logic scan_empty;
    logic scan_hit;
    logic shift_done;
  } status_t;

  function automatic logic [StoreAw-1:0] stack_base(input logic [OrdW-1:0] o);
    logic [StoreAw:0] full;
    full = (StoreAw + 1)'(StoreDepth);
    return StoreAw'(full - (full >> o));
  endfunction

  function automatic logic [DepthW-1:0] stack_cap(input logic [OrdW-1:0] o);
    return DepthW'(BlockCount >> o);
  endfunction

endpackage

@@ rtl/core/buddy_block_allocator.sv @@
// Top level of the buddy block allocator.
// Depends on bba_pkg, bba_ctrl and bba_dpath.
//
// Usage: raise start with an item on req_i; it is taken when busy is low.
// opcode 0 allocates request_bytes plus an 8-byte tag, opcode 1 frees
// free_block. Exactly one result per item appears on rsp_o with rsp_valid_o
// high for one cycle; the receiver cannot hold it off.
// A granted allocation finds the fitting order, searches up to the first order
// with a free block, pops that block and splits it down to the fitting order;
// a refused one ends after the search. A free reads the block's tag, then per
// merged level scans the stack for the buddy and shifts each entry above the
// buddy down; it pushes the block at the first level whose buddy is absent
// or at the top order.
// Items are handled one at a time; busy stays high until the result and the
// next item is taken in the cycle after the result at the earliest.
// Writing pool_bytes via cfg_we_i resets the depths and top order at once and
// writes the whole pool entry at the next edge; write it only while idle.
// Reset puts the whole 64 KiB pool on the top order stack.
module buddy_block_allocator (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  bba_pkg::req_t  req_i,
  output logic           rsp_valid_o,
  output bba_pkg::rsp_t  rsp_o,
  input  logic           cfg_we_i,
  input  logic [16:0]    cfg_wdata_i
);
  import bba_pkg::*;

  cmd_e    cmd;
  status_t st;

  bba_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .opcode_i(req_i.opcode),
    .st_i(st), .cmd_o(cmd), .busy(busy), .done_o(rsp_valid_o)
  );

  bba_dpath u_dpath (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we(cfg_we_i), .cfg_wdata(cfg_wdata_i),
    .req_i(req_i), .cmd_i(cmd), .st_o(st), .rsp_o(rsp_o)
  );

endmodule

@@ rtl/core/bba_ctrl.sv @@
// Controller state machine of the buddy block allocator.
// Depends on bba_pkg; drives commands to bba_dpath and reads its status.
module bba_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic            opcode_i,
  input  bba_pkg::status_t st_i,
  output bba_pkg::cmd_e   cmd_o,
  output logic            busy,
  output logic            done_o
);
  import bba_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o = CmdNone;
    done_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o = CmdLoad;
          state_d = opcode_i ? StTagRd : StNeed;
        end
      end
      StNeed: begin
        if (st_i.need_fail) begin
          done_o = 1'b1;
          state_d = StIdle;
        end else if (st_i.need_done) begin
          state_d = StFind;
        end else begin
          cmd_o = CmdNeedStep;
        end
      end
      StFind: begin
        if (st_i.find_fail) begin
          done_o = 1'b1;
          state_d = StIdle;
        end else if (st_i.find_done) begin
          state_d = StPopRd;
        end else begin
          cmd_o = CmdFindStep;
        end
      end
      StPopRd: begin
        cmd_o = CmdPopRead;
        state_d = StPopWait;
      end
      StPopWait: begin
        cmd_o = CmdPopTake;
        state_d = StSplit;
      end
      StSplit: begin
        cmd_o = CmdSplitStep;
        if (st_i.split_done) begin
          done_o = 1'b1;
          state_d = StIdle;
        end
      end
      StTagRd: begin
        cmd_o = CmdTagRead;
        state_d = StTagWait;
      end
      StTagWait: begin
        cmd_o = CmdTagTake;
        state_d = StMrgChk;
      end
      StMrgChk: begin
        if (st_i.merge_end) begin
          state_d = StPush;
        end else begin
          cmd_o = CmdScanStart;
          state_d = StScanRd;
        end
      end
      StScanRd: begin
        if (st_i.scan_empty) begin
          state_d = StPush;
        end else begin
          cmd_o = CmdScanRead;
          state_d = StScanWait;
        end
      end
      StScanWait: state_d = StScanCmp;
      StScanCmp: begin
        if (st_i.scan_hit) begin
          state_d = StShiftRd;
        end else begin
          cmd_o = CmdScanNext;
          state_d = StScanRd;
        end
      end
      StShiftRd: begin
        if (st_i.shift_done) begin
          cmd_o = CmdMerge;
          state_d = StMrgChk;
        end else begin
          cmd_o = CmdShiftRead;
          state_d = StShiftWait;
        end
      end
      StShiftWait: state_d = StShiftWr;
      StShiftWr: begin
        cmd_o = CmdShiftWrite;
        state_d = StShiftRd;
      end
      StPush: begin
        cmd_o = CmdPush;
        done_o = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !busy)
    else $error("busy after result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (start && !busy) |=> busy)
    else $error("item not taken");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy |-> !done_o)
    else $error("result while idle");

endmodule

@@ rtl/core/bba_dpath.sv @@
// Datapath of the buddy block allocator: free stack memory, tag memory,
// depth counters and working registers. Depends on bba_pkg.
module bba_dpath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we,
  input  logic [16:0]      cfg_wdata,
  input  bba_pkg::req_t    req_i,
  input  bba_pkg::cmd_e    cmd_i,
  output bba_pkg::status_t st_o,
  output bba_pkg::rsp_t    rsp_o
);
  import bba_pkg::*;

  logic [BlkW-1:0]   store_mem [StoreDepth];
  logic [OrdW-1:0]   tag_mem [BlockCount];
  logic [DepthW-1:0] depth_q [OrderLimit+1];
  logic [OrdW-1:0]   top_q;
  logic [BlkW-1:0]   rd_q;
  logic [OrdW-1:0]   tag_rd_q;
  logic              init_q;

  logic        op_q;
  logic [32:0] total_q;
  logic [16:0] size_q;
  logic [OrdW-1:0] need_q, f_q, o_q;
  logic [BlkW-1:0] b_q, buddy_q;
  logic [DepthW-1:0] i_q;
  logic        fail_q;

  logic [OrdW-1:0] top_new;
  always_comb begin
    top_new = '0;
    for (int t = 1; t <= OrderLimit; t++) begin
      if ((17'(UnitBytes) << t) <= cfg_wdata) top_new = OrdW'(t);
    end
  end

  logic [StoreAw-1:0] rd_addr;
  logic               rd_en;
  logic               wr_en;
  logic [StoreAw-1:0] wr_addr;
  logic [BlkW-1:0]    wr_data;
  logic [BlkW-1:0]    blk_mask, split_blk;
  logic [OrdW-1:0]    f_dec, o_sat;
  logic [BlkW-1:0]    tag_addr;

  assign blk_mask = BlkW'((1 << top_q) - 1);
  assign f_dec = f_q - 1'b1;
  assign split_blk = b_q + (BlkW'(1) << f_dec);
  assign o_sat = (tag_rd_q > top_q) ? top_q : tag_rd_q;
  assign tag_addr = req_i.free_block & blk_mask;
  assign rd_en = (cmd_i == CmdPopRead) || (cmd_i == CmdScanRead) ||
                 (cmd_i == CmdShiftRead);

  always_comb begin
    rd_addr = stack_base(f_q) + StoreAw'(depth_q[f_q] - 1'b1);
    wr_en = 1'b0;
    wr_addr = '0;
    wr_data = split_blk;
    unique case (cmd_i)
      CmdScanRead: rd_addr = stack_base(o_q) + StoreAw'(i_q - 1'b1);
      CmdShiftRead: rd_addr = stack_base(o_q) + StoreAw'(i_q + 1'b1);
      CmdSplitStep: begin
        wr_en = (f_q != need_q) && (depth_q[f_dec] < stack_cap(f_dec));
        wr_addr = stack_base(f_dec) + StoreAw'(depth_q[f_dec]);
      end
      CmdShiftWrite: begin
        wr_en = 1'b1;
        wr_addr = stack_base(o_q) + StoreAw'(i_q);
        wr_data = rd_q;
      end
      CmdPush: begin
        wr_en = (depth_q[o_q] < stack_cap(o_q));
        wr_addr = stack_base(o_q) + StoreAw'(depth_q[o_q]);
        wr_data = b_q;
      end
      default: ;
    endcase
    // The whole pool, block 0, is placed on the top order stack after an init.
    if (init_q) begin
      wr_en = 1'b1;
      wr_addr = stack_base(top_q);
      wr_data = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) store_mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= store_mem[rd_addr];
    if (cmd_i == CmdSplitStep && f_q == need_q) tag_mem[b_q] <= need_q;
    tag_rd_q <= tag_mem[b_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= OrdW'(OrderLimit);
      for (int k = 0; k <= OrderLimit; k++) depth_q[k] <= '0;
      depth_q[OrderLimit] <= DepthW'(1);
      op_q <= 1'b0;
      fail_q <= 1'b0;
      init_q <= 1'b1;
    end else if (cfg_we) begin
      top_q <= top_new;
      for (int k = 0; k <= OrderLimit; k++) depth_q[k] <= '0;
      depth_q[top_new] <= DepthW'(1);
      init_q <= 1'b1;
    end else begin
      init_q <= 1'b0;
      unique case (cmd_i)
        CmdLoad: begin
          op_q <= req_i.opcode;
          fail_q <= (req_i.request_bytes == '0);
          total_q <= {1'b0, req_i.request_bytes} + 33'(TagBytes);
          size_q <= 17'(UnitBytes);
          need_q <= '0;
          b_q <= tag_addr;
        end
        CmdNeedStep: begin
          size_q <= size_q << 1;
          need_q <= need_q + 1'b1;
          f_q <= need_q + 1'b1;
        end
        CmdFindStep: f_q <= f_q + 1'b1;
        CmdPopTake: begin
          depth_q[f_q] <= depth_q[f_q] - 1'b1;
          b_q <= rd_q;
        end
        CmdSplitStep: begin
          if (f_q != need_q) begin
            if (depth_q[f_dec] < stack_cap(f_dec))
              depth_q[f_dec] <= depth_q[f_dec] + 1'b1;
            f_q <= f_dec;
          end
        end
        CmdTagTake: begin
          o_q <= o_sat;
          b_q <= b_q & ~BlkW'((1 << o_sat) - 1);
        end
        CmdScanStart: begin
          i_q <= depth_q[o_q];
          buddy_q <= b_q ^ (BlkW'(1) << o_q);
        end
        CmdScanRead: i_q <= i_q - 1'b1;
        CmdScanNext: ;
        CmdShiftWrite: i_q <= i_q + 1'b1;
        CmdMerge: begin
          depth_q[o_q] <= depth_q[o_q] - 1'b1;
          if (buddy_q < b_q) b_q <= buddy_q;
          o_q <= o_q + 1'b1;
        end
        CmdPush: begin
          if (depth_q[o_q] < stack_cap(o_q)) depth_q[o_q] <= depth_q[o_q] + 1'b1;
        end
        default: ;
      endcase
      if (cmd_i == CmdLoad) f_q <= '0;
    end
  end

  // The need search stops at the first size that covers the request.
  logic need_over;
  assign need_over = (need_q == top_q);
  assign st_o.need_fail = fail_q || ({16'd0, size_q} < total_q && need_over);
  assign st_o.need_done = ({16'd0, size_q} >= total_q);
  assign st_o.find_done = (depth_q[f_q] != '0);
  assign st_o.find_fail = (depth_q[f_q] == '0) && (f_q == top_q);
  assign st_o.split_done = (f_q == need_q);
  assign st_o.merge_end = (o_q >= top_q);
  assign st_o.scan_empty = (i_q == '0);
  assign st_o.scan_hit = (rd_q == buddy_q);
  assign st_o.shift_done = (i_q + 1'b1 >= depth_q[o_q]);

  always_comb begin
    rsp_o = '0;
    if (op_q) begin
      rsp_o.granted = 1'b1;
      rsp_o.block_start = b_q;
      rsp_o.block_order = o_q;
    end else if (cmd_i == CmdSplitStep) begin
      rsp_o.granted = 1'b1;
      rsp_o.block_start = b_q;
      rsp_o.block_order = need_q;
    end
  end

endmodule
